// ===== rtl/core/wcfd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wcfd_pkg
// Codes, field widths and the CRC-8 byte step of the word framer/deframer.
// ----------------------------------------------------------------------------
package wcfd_pkg;

  localparam int unsigned ActW    = 2;
  localparam int unsigned WordW   = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 32;

  localparam logic [ActW-1:0] ACT_CMD = 2'd0;
  localparam logic [ActW-1:0] ACT_ARG = 2'd1;
  localparam logic [ActW-1:0] ACT_RX  = 2'd2;

  localparam logic [StatusW-1:0] ST_OK      = 2'd0;
  localparam logic [StatusW-1:0] ST_BAD_CRC = 2'd1;
  localparam logic [StatusW-1:0] ST_DISCARD = 2'd2;

  localparam logic KIND_TX = 1'b0;
  localparam logic KIND_RX = 1'b1;

  localparam logic [ByteW-1:0] CRC_POLY = 8'h31;
  localparam logic [ByteW-1:0] CRC_INIT = 8'hFF;

  // one byte through CRC-8, MSB first
  function automatic logic [ByteW-1:0] crc_byte(input logic [ByteW-1:0] crc_in,
                                                input logic [ByteW-1:0] data);
    logic [ByteW-1:0] c;
    c = crc_in ^ data;
    for (int b = 0; b < ByteW; b++) begin
      if (c[ByteW-1]) begin
        c = {c[ByteW-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[ByteW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/word_crc8_framer_deframer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// word_crc8_framer_deframer
// Sends command/argument words as bus bytes with CRC-8, regroups received
// bytes into words and checks their CRC.
// ----------------------------------------------------------------------------
// Order: a request is registered in the request register, and each of its
//   results is then registered in the output register.
// Throughput: one result per cycle while the output is not stalled; a command
//   gives 2 bytes, an argument 3, a received byte 1 only if it ends a word.
// Reset (rst_n low, synchronous): pipeline empty, receive position, held
//   bytes and read failure flag cleared.
module word_crc8_framer_deframer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [wcfd_pkg::InDataW-1:0]  in_tdata,   // data_word[15:0], rx_byte[23:16]
  input  wire logic [2:0]                    in_tuser,   // action[1:0], first_of_read[2]
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [wcfd_pkg::OutDataW-1:0]      out_tdata,  // tx_byte[7:0], rx_word[23:8],
                                                         // rx_status[25:24]
  output logic                               out_tuser,  // out_kind
  output logic                               out_tlast
);

  // request register
  logic                                it_valid_r, it_valid_nxt;
  logic [wcfd_pkg::ActW-1:0]           it_act_r;
  logic [wcfd_pkg::WordW-1:0]          it_word_r;
  logic [wcfd_pkg::ByteW-1:0]          it_rx_r;
  logic                                it_first_r;
  logic [wcfd_pkg::ByteW-1:0]          it_crc_r;
  logic [1:0]                          it_idx_r, it_idx_nxt;

  // receive state
  logic [1:0]                          pos_r, pos_nxt;
  logic [wcfd_pkg::ByteW-1:0]          hi_r, hi_nxt;
  logic [wcfd_pkg::ByteW-1:0]          lo_r, lo_nxt;
  logic [wcfd_pkg::ByteW-1:0]          rcrc_r, rcrc_nxt;
  logic                                fail_r, fail_nxt;

  // output register
  logic                                out_valid_r, out_valid_nxt;
  logic                                o_kind_r;
  logic [wcfd_pkg::ByteW-1:0]          o_tx_r;
  logic [wcfd_pkg::WordW-1:0]          o_word_r;
  logic [wcfd_pkg::StatusW-1:0]        o_stat_r;
  logic                                o_last_r;

  logic                                accept, out_free, emit, done;
  logic [1:0]                          pos_eff, n_res;
  logic                                r_kind, r_last;
  logic [wcfd_pkg::ByteW-1:0]          r_tx;
  logic [wcfd_pkg::StatusW-1:0]        r_stat;
  logic [wcfd_pkg::ByteW-1:0]          w_hi, w_lo;

  assign w_hi = it_word_r[15:8];
  assign w_lo = it_word_r[7:0];
  assign pos_eff = (it_first_r || pos_r == 2'd3) ? 2'd0 : pos_r;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    case (it_act_r)
      wcfd_pkg::ACT_CMD: n_res = 2'd2;
      wcfd_pkg::ACT_ARG: n_res = 2'd3;
      wcfd_pkg::ACT_RX:  n_res = (pos_eff == 2'd2) ? 2'd1 : 2'd0;
      default:           n_res = 2'd0;
    endcase
  end

  assign emit = it_valid_r && (n_res != 2'd0) && out_free;
  assign r_last = (it_idx_r == n_res - 2'd1);
  assign done = it_valid_r && ((n_res == 2'd0) || (emit && r_last));
  assign in_tready = !it_valid_r || done;
  assign accept = in_tvalid && in_tready;

  // result selection
  always_comb begin
    r_kind = wcfd_pkg::KIND_TX;
    r_tx   = '0;
    r_stat = wcfd_pkg::ST_OK;
    if (it_act_r == wcfd_pkg::ACT_RX) begin
      r_kind = wcfd_pkg::KIND_RX;
      if (fail_r) begin
        r_stat = wcfd_pkg::ST_DISCARD;
      end else if (rcrc_r == it_rx_r) begin
        r_stat = wcfd_pkg::ST_OK;
      end else begin
        r_stat = wcfd_pkg::ST_BAD_CRC;
      end
    end else begin
      case (it_idx_r)
        2'd0:    r_tx = w_hi;
        2'd1:    r_tx = w_lo;
        default: r_tx = wcfd_pkg::crc_byte(it_crc_r, w_lo);
      endcase
    end
  end

  // request register and receive state
  always_comb begin
    it_valid_nxt = it_valid_r;
    it_idx_nxt   = it_idx_r;
    pos_nxt      = pos_r;
    hi_nxt       = hi_r;
    lo_nxt       = lo_r;
    rcrc_nxt     = rcrc_r;
    fail_nxt     = fail_r;
    if (emit && !r_last) begin
      it_idx_nxt = it_idx_r + 2'd1;
    end
    if (done) begin
      it_valid_nxt = 1'b0;
      if (it_act_r == wcfd_pkg::ACT_RX) begin
        if (it_first_r) begin
          fail_nxt = 1'b0;
        end
        case (pos_eff)
          2'd0: begin
            hi_nxt   = it_rx_r;
            rcrc_nxt = wcfd_pkg::crc_byte(wcfd_pkg::CRC_INIT, it_rx_r);
            pos_nxt  = 2'd1;
          end
          2'd1: begin
            lo_nxt   = it_rx_r;
            rcrc_nxt = wcfd_pkg::crc_byte(rcrc_r, it_rx_r);
            pos_nxt  = 2'd2;
          end
          default: begin
            pos_nxt = 2'd0;
            if (r_stat == wcfd_pkg::ST_BAD_CRC) begin
              fail_nxt = 1'b1;
            end
          end
        endcase
      end
    end
    if (accept) begin
      it_valid_nxt = 1'b1;
      it_idx_nxt   = 2'd0;
    end
  end

  assign out_valid_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_valid_r  <= 1'b0;
      it_idx_r    <= '0;
      pos_r       <= '0;
      hi_r        <= '0;
      lo_r        <= '0;
      rcrc_r      <= '0;
      fail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      it_valid_r  <= it_valid_nxt;
      it_idx_r    <= it_idx_nxt;
      pos_r       <= pos_nxt;
      hi_r        <= hi_nxt;
      lo_r        <= lo_nxt;
      rcrc_r      <= rcrc_nxt;
      fail_r      <= fail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it_act_r   <= in_tuser[1:0];
      it_first_r <= in_tuser[2];
      it_word_r  <= in_tdata[15:0];
      it_rx_r    <= in_tdata[23:16];
      it_crc_r   <= wcfd_pkg::crc_byte(wcfd_pkg::CRC_INIT, in_tdata[15:8]);
    end
    if (emit) begin
      o_kind_r <= r_kind;
      o_tx_r   <= r_tx;
      o_word_r <= (r_kind == wcfd_pkg::KIND_RX) ? {hi_r, lo_r} : '0;
      o_stat_r <= r_stat;
      o_last_r <= r_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, o_stat_r, o_word_r, o_tx_r};
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;

endmodule
`default_nettype wire
